/* hw/rtl/lsof_pkg.sv */
// ============================================================================
// lsof_pkg
// Shared types, constants and helpers for the lidar sector obstacle flags.
// ============================================================================
package lsof_pkg;

    localparam int SECTORS = 6;
    localparam int CNT_W   = 13;
    localparam int ANG_W   = 15;
    localparam int DIST_W  = 16;
    localparam int BND_W   = 2 * ANG_W;
    localparam int LIM_W   = 4 * DIST_W;
    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 64;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Sector positions in the flag vector and in the bounds array.
    localparam int SEC_FRONT_MID   = 0;
    localparam int SEC_FRONT_LEFT  = 1;
    localparam int SEC_FRONT_RIGHT = 2;
    localparam int SEC_REAR_MID    = 3;
    localparam int SEC_REAR_LEFT   = 4;
    localparam int SEC_REAR_RIGHT  = 5;

    typedef enum logic [2:0] {
        REG_FRONT_MID_BOUNDS   = 3'd0,
        REG_FRONT_LEFT_BOUNDS  = 3'd1,
        REG_FRONT_RIGHT_BOUNDS = 3'd2,
        REG_REAR_MID_BOUNDS    = 3'd3,
        REG_REAR_LEFT_BOUNDS   = 3'd4,
        REG_REAR_RIGHT_BOUNDS  = 3'd5,
        REG_DISTANCE_LIMITS    = 3'd6,
        REG_COUNT_THRESHOLD    = 3'd7
    } t_reg_idx;

    // Reset bounds, left bound in the upper half and right bound in the lower.
    localparam logic [SECTORS-1:0][BND_W-1:0] BOUNDS_RST = {
        30'd41947520,   // rear right
        30'd608195840,  // rear left
        30'd713032960,  // rear middle
        30'd398474880,  // front right
        30'd230697600,  // front left
        30'd335557120   // front middle
    };

    typedef struct packed {
        logic [SECTORS-1:0][BND_W-1:0] bounds;
        logic [LIM_W-1:0]              limits;
        logic [CNT_W-1:0]              threshold;
    } t_cfg;

    // Distance limit for a sector; front sides share one, rear sides another.
    function automatic logic [DIST_W-1:0] sector_limit(input int s,
                                                       input logic [LIM_W-1:0] lim);
        logic [DIST_W-1:0] r;
        case (s)
            SEC_FRONT_MID:                   r = lim[1*DIST_W-1:0*DIST_W];
            SEC_FRONT_LEFT, SEC_FRONT_RIGHT: r = lim[2*DIST_W-1:1*DIST_W];
            SEC_REAR_MID:                    r = lim[3*DIST_W-1:2*DIST_W];
            default:                         r = lim[4*DIST_W-1:3*DIST_W];
        endcase
        return r;
    endfunction

    // Inclusive angle window; wraps through zero when left exceeds right.
    function automatic logic in_sector(input logic [ANG_W-1:0] angle,
                                       input logic [BND_W-1:0] bounds);
        logic [ANG_W-1:0] left;
        logic [ANG_W-1:0] right;
        left  = bounds[BND_W-1:ANG_W];
        right = bounds[ANG_W-1:0];
        if (left <= right) begin
            return (angle >= left) && (angle <= right);
        end
        return (angle >= left) || (angle <= right);
    endfunction

endpackage

/* hw/rtl/lsof_cfg_regs.sv */
// ============================================================================
// lsof_cfg_regs
// APB register file holding sector bounds, distance limits and threshold.
// ============================================================================
module lsof_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lsof_pkg::ADDR_W-1:0] paddr,
    input  logic [lsof_pkg::DATA_W-1:0] pwdata,
    output logic [lsof_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output lsof_pkg::t_cfg              o_cfg
);
    import lsof_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:3]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bounds    <= BOUNDS_RST;
            r_cfg.limits    <= '0;
            r_cfg.threshold <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_FRONT_MID_BOUNDS:
                    r_cfg.bounds[SEC_FRONT_MID]   <= pwdata[BND_W-1:0];
                REG_FRONT_LEFT_BOUNDS:
                    r_cfg.bounds[SEC_FRONT_LEFT]  <= pwdata[BND_W-1:0];
                REG_FRONT_RIGHT_BOUNDS:
                    r_cfg.bounds[SEC_FRONT_RIGHT] <= pwdata[BND_W-1:0];
                REG_REAR_MID_BOUNDS:
                    r_cfg.bounds[SEC_REAR_MID]    <= pwdata[BND_W-1:0];
                REG_REAR_LEFT_BOUNDS:
                    r_cfg.bounds[SEC_REAR_LEFT]   <= pwdata[BND_W-1:0];
                REG_REAR_RIGHT_BOUNDS:
                    r_cfg.bounds[SEC_REAR_RIGHT]  <= pwdata[BND_W-1:0];
                REG_DISTANCE_LIMITS:
                    r_cfg.limits                  <= pwdata[LIM_W-1:0];
                REG_COUNT_THRESHOLD:
                    r_cfg.threshold               <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_FRONT_MID_BOUNDS:
                prdata = DATA_W'(r_cfg.bounds[SEC_FRONT_MID]);
            REG_FRONT_LEFT_BOUNDS:
                prdata = DATA_W'(r_cfg.bounds[SEC_FRONT_LEFT]);
            REG_FRONT_RIGHT_BOUNDS:
                prdata = DATA_W'(r_cfg.bounds[SEC_FRONT_RIGHT]);
            REG_REAR_MID_BOUNDS:
                prdata = DATA_W'(r_cfg.bounds[SEC_REAR_MID]);
            REG_REAR_LEFT_BOUNDS:
                prdata = DATA_W'(r_cfg.bounds[SEC_REAR_LEFT]);
            REG_REAR_RIGHT_BOUNDS:
                prdata = DATA_W'(r_cfg.bounds[SEC_REAR_RIGHT]);
            REG_DISTANCE_LIMITS:
                prdata = DATA_W'(r_cfg.limits);
            REG_COUNT_THRESHOLD:
                prdata = DATA_W'(r_cfg.threshold);
            default:
                prdata = '0;
        endcase
    end

endmodule

/* hw/rtl/lsof_sector_cnt.sv */
// ============================================================================
// lsof_sector_cnt
// Per-sector angle/distance match, saturating hit counters and scan flags.
// ============================================================================
module lsof_sector_cnt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lsof_pkg::t_cfg               i_cfg,
    input  logic                         i_step,
    input  logic [lsof_pkg::ANG_W-1:0]   i_angle,
    input  logic [lsof_pkg::DIST_W-1:0]  i_distance,
    input  logic                         i_last,
    output logic [lsof_pkg::SECTORS-1:0] o_hits
);
    import lsof_pkg::*;

    logic [CNT_W-1:0] r_cnt [SECTORS];
    logic [CNT_W-1:0] n_cnt [SECTORS];

    for (genvar s = 0; s < SECTORS; s++) begin : g_sec
        logic w_inc;

        // A zero distance marks a dropped return and never counts.
        assign w_inc = (i_distance != '0)
                    && in_sector(i_angle, i_cfg.bounds[s])
                    && (i_distance < sector_limit(s, i_cfg.limits))
                    && (r_cnt[s] != CNT_MAX);

        assign n_cnt[s]  = r_cnt[s] + CNT_W'(w_inc);
        assign o_hits[s] = n_cnt[s] > i_cfg.threshold;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cnt[s] <= '0;
            end else if (i_step) begin
                r_cnt[s] <= i_last ? '0 : n_cnt[s];
            end
        end
    end

endmodule

/* hw/rtl/lidar_sector_obstacle_flags.sv */
// ============================================================================
// lidar_sector_obstacle_flags
// Counts close lidar returns in six angular sectors and flags obstacles once
// per scan.
// ============================================================================
//
//  Channel  Handshake                 Word
//  -------  ------------------------  -------------------------------------
//  in       i_in_valid / o_in_ready   angle, distance, end of scan
//  out      o_out_valid / i_out_ready obstacle ahead, obstacle rear, flags
//  cfg      APB psel/penable/pwrite   8 registers at byte address 8*index
//
//  A point is registered on acceptance, then counted, so one point is taken
//  every clock unless stalled. The point that ends a scan passes from the
//  input register to the output register. Only an end-of-scan point can
//  stall the input register, and only while an earlier result is still
//  waiting at the output. Reset is synchronous and active low; it restores
//  the default sector bounds, clears limits, threshold and all counters.
//
module lidar_sector_obstacle_flags (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Point input.
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [lsof_pkg::ANG_W-1:0]   i_point_angle,
    input  logic [lsof_pkg::DIST_W-1:0]  i_point_distance,
    input  logic                         i_end_of_scan,
    // Scan result output.
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_obstacle_ahead,
    output logic                         o_obstacle_rear,
    output logic [lsof_pkg::SECTORS-1:0] o_sector_hits,
    // Configuration port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lsof_pkg::ADDR_W-1:0]  paddr,
    input  logic [lsof_pkg::DATA_W-1:0]  pwdata,
    output logic [lsof_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import lsof_pkg::*;

    t_cfg w_cfg;

    // Input register: holds one point until the counters take it.
    logic               r_in_valid;
    logic [ANG_W-1:0]   r_in_angle;
    logic [DIST_W-1:0]  r_in_dist;
    logic               r_in_last;

    // Output register: one scan result waiting for the consumer.
    logic               r_out_valid;
    logic [SECTORS-1:0] r_out_hits;

    logic               w_step;
    logic               w_accept;
    logic [SECTORS-1:0] w_hits;

    lsof_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The registered point is counted this cycle unless it closes a scan and
    // the output register is still occupied by a result nobody has taken.
    assign w_step     = r_in_valid && (!r_in_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_step;
    assign w_accept   = i_in_valid && o_in_ready;

    lsof_sector_cnt u_cnt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_step     (w_step),
        .i_angle    (r_in_angle),
        .i_distance (r_in_dist),
        .i_last     (r_in_last),
        .o_hits     (w_hits)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_angle <= i_point_angle;
            r_in_dist  <= i_point_distance;
            r_in_last  <= i_end_of_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && r_in_last) begin
            r_out_hits <= w_hits;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_sector_hits    = r_out_hits;
    assign o_obstacle_ahead = r_out_hits[SEC_FRONT_MID] || r_out_hits[SEC_FRONT_LEFT]
                           || r_out_hits[SEC_FRONT_RIGHT];
    assign o_obstacle_rear  = r_out_hits[SEC_REAR_MID] || r_out_hits[SEC_REAR_LEFT]
                           || r_out_hits[SEC_REAR_RIGHT];

`ifndef SYNTHESIS
    // A scan-closing point that is counted always leaves a result behind.
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_in_last) |=> r_out_valid)
        else $error("scan end counted without a result");

    // A registered point that was not counted is still held.
    a_point_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_step) |=> r_in_valid)
        else $error("registered point dropped");

    // A result is never overwritten while the consumer has not taken it.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_in_last) |-> (!r_out_valid || i_out_ready))
        else $error("pending result overwritten");
`endif

endmodule
